[rtl/core/gts_pkg.sv]
package gts_pkg;

  localparam int NSPEC      = 61;
  localparam int FUNC_W     = 3;
  localparam int IDX_W      = 12;
  localparam int COLOR_W    = 2;
  localparam int VALUE_W    = 48;
  localparam int RAND_W     = 32;
  localparam int TIME_W     = 48;
  localparam int KIND_W     = 3;
  localparam int SP_W       = 6;
  localparam int CNT_W      = 16;
  localparam int SLOT_W     = 8;
  localparam int POS_W      = 12;
  localparam int RCNT_W     = 8;
  localparam int INT_W      = 24;
  localparam int RATE_W     = 32;
  localparam int FP_W       = 6;
  localparam int A0_W       = 56;
  localparam int NUM_W      = 38;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [CFG_IDX_W-1:0] reg_idx_t;

  localparam func_t FN_CODON  = 3'd0;
  localparam func_t FN_CHARGE = 3'd1;
  localparam func_t FN_PROBE  = 3'd2;
  localparam func_t FN_START  = 3'd3;
  localparam func_t FN_TIME   = 3'd4;
  localparam func_t FN_EVENT  = 3'd5;

  localparam kind_t K_CHARGE   = 3'd0;
  localparam kind_t K_DECAY    = 3'd1;
  localparam kind_t K_INITIATE = 3'd2;
  localparam kind_t K_ELONGATE = 3'd3;
  localparam kind_t K_COMPLETE = 3'd4;
  localparam kind_t K_NONE     = 3'd5;

  localparam reg_idx_t REG_RATE_BIND     = 3'd0;
  localparam reg_idx_t REG_RATE_COMPLETE = 3'd1;
  localparam reg_idx_t REG_RATE_ELONG    = 3'd2;
  localparam reg_idx_t REG_RATE_DIFFUSE  = 3'd3;
  localparam reg_idx_t REG_FOOTPRINT     = 3'd4;
  localparam reg_idx_t REG_GENE_LENGTH   = 3'd5;
  localparam reg_idx_t REG_INHIBIT_EN    = 3'd6;
  localparam reg_idx_t REG_INHIBIT_TIME  = 3'd7;

  // ln(2) as an unsigned Q0.32 fraction.
  localparam logic [31:0] LN2_Q32 = 32'd2977044471;

  typedef struct packed {
    logic start;
    logic [NUM_W-1:0] num;
    logic [A0_W-1:0] den;
  } div_req_t;

endpackage

[rtl/core/gts_if.sv]
interface gts_in_if;
  import gts_pkg::*;
  logic valid;
  logic ready;
  logic [FUNC_W-1:0] func;
  logic [IDX_W-1:0] index;
  logic [COLOR_W-1:0] color;
  logic [VALUE_W-1:0] value;
  logic [RAND_W-1:0] random_time;
  logic [RAND_W-1:0] random_pick;
  modport source (output valid, func, index, color, value, random_time, random_pick,
                  input ready);
  modport sink (input valid, func, index, color, value, random_time, random_pick,
                output ready);
endinterface

interface gts_out_if;
  import gts_pkg::*;
  logic valid;
  logic ready;
  logic [TIME_W-1:0] sim_time;
  logic [KIND_W-1:0] reaction_kind;
  logic [SP_W-1:0] species;
  logic [CNT_W-1:0] species_count;
  logic [SLOT_W-1:0] rib_slot;
  logic [POS_W-1:0] rib_position;
  logic [RCNT_W-1:0] ribosome_count;
  logic [INT_W-1:0] intensity_0;
  logic [INT_W-1:0] intensity_1;
  logic [INT_W-1:0] intensity_2;
  modport source (output valid, sim_time, reaction_kind, species, species_count, rib_slot,
                  rib_position, ribosome_count, intensity_0, intensity_1, intensity_2,
                  input ready);
  modport sink (input valid, sim_time, reaction_kind, species, species_count, rib_slot,
                rib_position, ribosome_count, intensity_0, intensity_1, intensity_2,
                output ready);
endinterface

[rtl/core/gts_mul.sv]
module gts_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);
  always_ff @(posedge clk) begin
    prod <= a * b;
  end
endmodule

[rtl/core/gts_div.sv]
module gts_div (
  input  logic clk,
  input  logic rst,
  input  gts_pkg::div_req_t req,
  output logic done,
  output logic [gts_pkg::NUM_W-1:0] quo
);
  import gts_pkg::*;

  localparam int CW = $clog2(NUM_W);

  logic busy;
  logic [CW-1:0] cnt;
  logic [A0_W-1:0] rem;
  logic [A0_W:0] rem_sh;
  logic take;

  assign rem_sh = {rem, quo[NUM_W-1]};
  assign take = rem_sh >= {1'b0, req.den};

  // Restoring division, one quotient bit per cycle, MSB first.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
        rem <= '0;
        quo <= req.num;
      end else if (busy) begin
        rem <= take ? A0_W'(rem_sh - {1'b0, req.den}) : rem_sh[A0_W-1:0];
        quo <= {quo[NUM_W-2:0], take};
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[rtl/core/gillespie_translation_step_top.sv]
// Gillespie direct-method step for ribosome translation over 61 tRNA pools. Load beats
// (codon map, charge rate, probe weight, start position, start time) give no result. An
// event beat gives one result: it sums the tRNA propensities species by species, reads
// each ribosome's position, codon species and pool through memories with a single read
// port, runs the squaring log on the shared 32x32 multiplier and the 38-bit bit-serial
// divider, walks the selection, and forms the intensity sums per ribosome and color. The
// input is not ready while an event is in progress. After reset a clearing pass zeroes
// ribosome positions and pool counts; configuration writes are taken during it, items
// are not.
module gillespie_translation_step_top #(
  parameter int MAX_RIBOSOMES   = 256,
  parameter int MAX_GENE_LENGTH = 4095,
  parameter int COLORS          = 3
) (
  input  logic clk,
  input  logic rst,
  gts_in_if.sink items,
  gts_out_if.source results,
  input  logic cfg_we,
  input  logic [gts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gts_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gts_pkg::*;

  localparam int RW = $clog2(MAX_RIBOSOMES);
  localparam int NW = $clog2(MAX_RIBOSOMES + 1);
  localparam int CDEPTH = (MAX_GENE_LENGTH + 1 < 4096) ? MAX_GENE_LENGTH + 1 : 4096;
  localparam int CAW = $clog2(CDEPTH);
  localparam int CLW = (COLORS > 1) ? $clog2(COLORS) : 1;
  localparam int ACC_W = CNT_W + NW;
  localparam int CLR_N = (MAX_RIBOSOMES > 64) ? MAX_RIBOSOMES : 64;
  localparam int CCW = $clog2(CLR_N);
  localparam logic [16:0] MGL = 17'(MAX_GENE_LENGTH);

  localparam logic [1:0] W_NONE = 2'd0;
  localparam logic [1:0] W_ELONG = 2'd1;
  localparam logic [1:0] W_COMP = 2'd2;

  localparam logic [5:0] S_CLR = 6'd0, S_IDLE = 6'd1, S_A_RD = 6'd2, S_A_ADD = 6'd3;
  localparam logic [5:0] S_A_MUL = 6'd4, S_R_RD = 6'd5, S_R_POS = 6'd6, S_R_SP = 6'd7;
  localparam logic [5:0] S_R_W = 6'd8, S_INIT = 6'd9, S_CHK = 6'd10, S_NORM = 6'd11;
  localparam logic [5:0] S_SQ = 6'd12, S_SQ2 = 6'd13, S_LN1 = 6'd14, S_LN2 = 6'd15;
  localparam logic [5:0] S_LN3 = 6'd16, S_DIVS = 6'd17, S_DIVW = 6'd18, S_T1 = 6'd19;
  localparam logic [5:0] S_T2 = 6'd20, S_T3 = 6'd21, S_C_RD = 6'd22, S_C_CMP = 6'd23;
  localparam logic [5:0] S_D_RD = 6'd24, S_D_MUL = 6'd25, S_D_CMP = 6'd26, S_P_RD = 6'd27;
  localparam logic [5:0] S_P_WR = 6'd28, S_W_RD = 6'd29, S_W_CMP = 6'd30, S_NEW = 6'd31;
  localparam logic [5:0] S_K_RD = 6'd32, S_K_WR = 6'd33, S_K_NP = 6'd34, S_K_NP2 = 6'd35;
  localparam logic [5:0] S_E_RD = 6'd36, S_E_POS = 6'd37, S_E_SP = 6'd38, S_E_WR = 6'd39;
  localparam logic [5:0] S_I_START = 6'd40, S_I_RD = 6'd41, S_I_POS = 6'd42;
  localparam logic [5:0] S_I_ADD = 6'd43, S_OUT = 6'd44;

  logic [5:0] state;
  logic [CCW-1:0] cl_cnt;

  logic [RATE_W-1:0] rate_bind, rate_complete, rate_elong, rate_diffuse;
  logic [FP_W-1:0] footprint;
  logic [POS_W-1:0] gene_length;
  logic inhibit_enable;
  logic [TIME_W-1:0] inhibit_time;
  logic [TIME_W-1:0] now_time;

  logic [RAND_W-1:0] r_pick;
  logic [A0_W-1:0] a0, cum, target;
  logic [SP_W-1:0] k;
  logic [NW-1:0] i_cnt, nr;
  logic [POS_W-1:0] prev_pos, cur_pos, newpos;
  logic [SP_W-1:0] cur_sp, species;
  logic [CNT_W-1:0] scount;
  logic [NW-1:0] slot;
  logic [KIND_W-1:0] kind;
  logic init_ok;
  logic [31:0] xr, frac, nlacc;
  logic [4:0] sh, it;
  logic [NUM_W-1:0] num;
  logic [1:0] c;
  logic [ACC_W-1:0] acc;
  logic [INT_W-1:0] inten [3];

  // Memories.
  logic [POS_W-1:0] rib_mem [2**RW];
  logic [1:0] w_mem [2**RW];
  logic [SP_W-1:0] cod_mem [2**CAW];
  logic [RATE_W-1:0] chg_mem [64];
  logic [CNT_W-1:0] pool_mem [64];
  logic [CNT_W-1:0] prb_mem [COLORS << CAW];

  logic rib_we, w_we, cod_we, chg_we, pool_we, prb_we;
  logic [RW-1:0] rib_wa, rib_ra, w_wa, w_ra;
  logic [POS_W-1:0] rib_wd, rib_rd;
  logic [1:0] w_wd, w_rd;
  logic [CAW-1:0] cod_wa, cod_ra;
  logic [SP_W-1:0] cod_wd, cod_rd;
  logic [SP_W-1:0] chg_wa, chg_ra, pool_wa, pool_ra;
  logic [RATE_W-1:0] chg_wd, chg_rd;
  logic [CNT_W-1:0] pool_wd, pool_rd, prb_wd, prb_rd;
  logic [CLW+CAW-1:0] prb_wa, prb_ra;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  div_req_t div_req;
  logic div_done;
  logic [NUM_W-1:0] div_quo;

  logic accept;
  logic [37:0] nl2;
  logic [32:0] y2;
  logic [A0_W-1:0] cum_c, cum_d, cum_w;
  logic [31:0] w_rib, w_sel;
  logic [1:0] w_code;
  logic gap_bad, blocked, is_comp;
  logic [NW-1:0] i_nx;
  logic [CNT_W-1:0] pool_inc, pool_dec;
  logic [TIME_W:0] t_sum;

  function automatic logic in_gene(input logic [POS_W-1:0] p);
    return {5'd0, p} <= MGL;
  endfunction

  always_ff @(posedge clk) begin
    if (rib_we) rib_mem[rib_wa] <= rib_wd;
    rib_rd <= rib_mem[rib_ra];
  end
  always_ff @(posedge clk) begin
    if (w_we) w_mem[w_wa] <= w_wd;
    w_rd <= w_mem[w_ra];
  end
  always_ff @(posedge clk) begin
    if (cod_we) cod_mem[cod_wa] <= cod_wd;
    cod_rd <= cod_mem[cod_ra];
  end
  always_ff @(posedge clk) begin
    if (chg_we) chg_mem[chg_wa] <= chg_wd;
    chg_rd <= chg_mem[chg_ra];
  end
  always_ff @(posedge clk) begin
    if (pool_we) pool_mem[pool_wa] <= pool_wd;
    pool_rd <= pool_mem[pool_ra];
  end
  always_ff @(posedge clk) begin
    if (prb_we) prb_mem[prb_wa] <= prb_wd;
    prb_rd <= prb_mem[prb_ra];
  end

  gts_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));
  gts_div u_div (.clk(clk), .rst(rst), .req(div_req), .done(div_done), .quo(div_quo));

  assign items.ready = (state == S_IDLE);
  assign accept = items.valid && items.ready;

  assign nl2 = {({1'b0, sh} + 6'd1), 32'd0} - {6'd0, frac};
  assign y2 = prod[63:31];
  assign cum_c = cum + A0_W'(chg_rd);
  assign cum_d = cum + A0_W'(prod);
  assign cum_w = cum + A0_W'(w_sel);
  assign i_nx = i_cnt + NW'(1);
  assign pool_inc = (pool_rd != '1) ? pool_rd + CNT_W'(1) : pool_rd;
  assign pool_dec = (pool_rd != '0) ? pool_rd - CNT_W'(1) : pool_rd;
  assign t_sum = {1'b0, now_time} + (TIME_W + 1)'(div_quo);

  // Propensity class of the ribosome being scanned.
  assign is_comp = (i_cnt == '0) && (cur_pos >= gene_length);
  assign gap_bad = ($signed({1'b0, prev_pos}) - $signed({1'b0, cur_pos}))
                   <= $signed({7'd0, footprint});
  assign blocked = ((i_cnt != '0) && gap_bad) || ((i_cnt != '0) && cur_pos >= gene_length)
                   || !in_gene(cur_pos) || (cur_sp >= SP_W'(NSPEC)) || (pool_rd == '0);
  assign w_code = is_comp ? W_COMP : (blocked ? W_NONE : W_ELONG);
  assign w_rib = is_comp ? rate_complete : (blocked ? '0 : rate_elong);

  always_comb begin
    if (i_cnt == nr) begin
      w_sel = init_ok ? rate_bind : '0;
    end else begin
      case (w_rd)
        W_ELONG: w_sel = rate_elong;
        W_COMP: w_sel = rate_complete;
        default: w_sel = '0;
      endcase
    end
  end

  always_comb begin
    rib_we = 1'b0; rib_wa = '0; rib_wd = '0; rib_ra = '0;
    w_we = 1'b0; w_wa = '0; w_wd = W_NONE; w_ra = '0;
    cod_we = 1'b0; cod_wa = '0; cod_wd = '0; cod_ra = '0;
    chg_we = 1'b0; chg_wa = '0; chg_wd = '0; chg_ra = '0;
    pool_we = 1'b0; pool_wa = '0; pool_wd = '0; pool_ra = '0;
    prb_we = 1'b0; prb_wa = '0; prb_wd = '0; prb_ra = '0;
    mul_a = '0; mul_b = '0;
    div_req.start = 1'b0;
    div_req.num = num;
    div_req.den = a0;
    case (state)
      S_CLR: begin
        rib_we = (32'(cl_cnt) < MAX_RIBOSOMES);
        rib_wa = cl_cnt[RW-1:0];
        pool_we = (32'(cl_cnt) < 64);
        pool_wa = cl_cnt[SP_W-1:0];
      end
      S_IDLE: begin
        cod_wa = items.index[CAW-1:0];
        cod_wd = items.value[SP_W-1:0];
        cod_we = accept && items.func == FN_CODON && ({5'd0, items.index} <= MGL);
        chg_wa = items.index[SP_W-1:0];
        chg_wd = items.value[RATE_W-1:0];
        chg_we = accept && items.func == FN_CHARGE && (items.index < IDX_W'(NSPEC));
        prb_wa = {items.color[CLW-1:0], items.index[CAW-1:0]};
        prb_wd = items.value[CNT_W-1:0];
        prb_we = accept && items.func == FN_PROBE && (32'(items.color) < COLORS)
                 && ({5'd0, items.index} <= MGL);
        rib_wa = items.index[RW-1:0];
        rib_wd = items.value[POS_W-1:0];
        rib_we = accept && items.func == FN_START && (32'(items.index) < MAX_RIBOSOMES);
      end
      S_A_RD: begin
        chg_ra = k;
        pool_ra = k;
      end
      S_A_ADD: begin
        mul_a = {16'd0, pool_rd};
        mul_b = rate_diffuse;
      end
      S_R_RD: rib_ra = i_cnt[RW-1:0];
      S_R_POS: cod_ra = rib_rd[CAW-1:0];
      S_R_SP: pool_ra = cod_rd;
      S_R_W: begin
        w_we = 1'b1;
        w_wa = i_cnt[RW-1:0];
        w_wd = w_code;
      end
      S_SQ: begin
        mul_a = xr;
        mul_b = xr;
      end
      S_LN1: begin
        mul_a = nl2[31:0];
        mul_b = LN2_Q32;
      end
      S_LN2: begin
        mul_a = {26'd0, nl2[37:32]};
        mul_b = LN2_Q32;
      end
      S_DIVS: div_req.start = 1'b1;
      S_T1: begin
        mul_a = r_pick;
        mul_b = a0[31:0];
      end
      S_T2: begin
        mul_a = r_pick;
        mul_b = {8'd0, a0[A0_W-1:32]};
      end
      S_C_RD: chg_ra = k;
      S_D_RD: pool_ra = k;
      S_D_MUL: begin
        mul_a = {16'd0, pool_rd};
        mul_b = rate_diffuse;
      end
      S_P_RD: pool_ra = k;
      S_P_WR: begin
        pool_we = 1'b1;
        pool_wa = k;
        pool_wd = (kind == K_CHARGE) ? pool_inc : pool_dec;
      end
      S_W_RD: w_ra = i_cnt[RW-1:0];
      S_NEW: begin
        rib_we = 1'b1;
        rib_wa = nr[RW-1:0];
        rib_wd = POS_W'(1);
      end
      S_K_RD: begin
        if (i_nx < nr) begin
          rib_ra = i_nx[RW-1:0];
        end else begin
          rib_we = 1'b1;
          rib_wa = i_cnt[RW-1:0];
        end
      end
      S_K_WR: begin
        rib_we = 1'b1;
        rib_wa = i_cnt[RW-1:0];
        rib_wd = rib_rd;
      end
      S_E_RD: rib_ra = slot[RW-1:0];
      S_E_POS: cod_ra = rib_rd[CAW-1:0];
      S_E_SP: pool_ra = cod_rd;
      S_E_WR: begin
        rib_we = 1'b1;
        rib_wa = slot[RW-1:0];
        rib_wd = cur_pos + POS_W'(1);
        pool_we = in_gene(cur_pos) && (cur_sp < SP_W'(NSPEC));
        pool_wa = cur_sp;
        pool_wd = pool_dec;
      end
      S_I_RD: rib_ra = i_cnt[RW-1:0];
      S_I_POS: prb_ra = {c[CLW-1:0], rib_rd[CAW-1:0]};
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_bind <= '0;
      rate_complete <= '0;
      rate_elong <= '0;
      rate_diffuse <= '0;
      footprint <= FP_W'(9);
      gene_length <= POS_W'(1);
      inhibit_enable <= 1'b0;
      inhibit_time <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RATE_BIND: rate_bind <= cfg_data[RATE_W-1:0];
        REG_RATE_COMPLETE: rate_complete <= cfg_data[RATE_W-1:0];
        REG_RATE_ELONG: rate_elong <= cfg_data[RATE_W-1:0];
        REG_RATE_DIFFUSE: rate_diffuse <= cfg_data[RATE_W-1:0];
        REG_FOOTPRINT: footprint <= cfg_data[FP_W-1:0];
        REG_GENE_LENGTH: gene_length <= cfg_data[POS_W-1:0];
        REG_INHIBIT_EN: inhibit_enable <= cfg_data[0];
        REG_INHIBIT_TIME: inhibit_time <= cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cl_cnt <= '0;
      now_time <= '0;
      nr <= '0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready) results.valid <= 1'b0;
      case (state)
        S_CLR: begin
          cl_cnt <= cl_cnt + CCW'(1);
          if (cl_cnt == CCW'(CLR_N - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept && items.func == FN_TIME) now_time <= items.value;
          if (accept && items.func == FN_EVENT) begin
            r_pick <= items.random_pick;
            xr <= (items.random_time != '0) ? items.random_time : 32'd1;
            sh <= '0;
            it <= '0;
            frac <= '0;
            a0 <= '0;
            k <= '0;
            i_cnt <= '0;
            prev_pos <= '0;
            kind <= K_NONE;
            species <= '0;
            scount <= '0;
            slot <= '0;
            newpos <= '0;
            inten[0] <= '0;
            inten[1] <= '0;
            inten[2] <= '0;
            state <= S_A_RD;
          end
        end
        S_A_RD: state <= S_A_ADD;
        S_A_ADD: begin
          a0 <= a0 + A0_W'(chg_rd);
          state <= S_A_MUL;
        end
        S_A_MUL: begin
          a0 <= a0 + A0_W'(prod);
          k <= k + SP_W'(1);
          state <= (k == SP_W'(NSPEC - 1)) ? S_R_RD : S_A_RD;
        end
        S_R_RD: state <= (i_cnt == NW'(MAX_RIBOSOMES)) ? S_INIT : S_R_POS;
        S_R_POS: begin
          cur_pos <= rib_rd;
          state <= (rib_rd == '0) ? S_INIT : S_R_SP;
        end
        S_R_SP: begin
          cur_sp <= cod_rd;
          state <= S_R_W;
        end
        S_R_W: begin
          a0 <= a0 + A0_W'(w_rib);
          prev_pos <= cur_pos;
          i_cnt <= i_nx;
          state <= S_R_RD;
        end
        S_INIT: begin
          nr <= i_cnt;
          // A new ribosome needs a free slot, a clear start region and no inhibitor.
          init_ok <= (i_cnt < NW'(MAX_RIBOSOMES - 1))
                     && (i_cnt == '0 || prev_pos > {6'd0, footprint})
                     && !(inhibit_enable && now_time >= inhibit_time);
          if ((i_cnt < NW'(MAX_RIBOSOMES - 1))
              && (i_cnt == '0 || prev_pos > {6'd0, footprint})
              && !(inhibit_enable && now_time >= inhibit_time)) begin
            a0 <= a0 + A0_W'(rate_bind);
          end
          state <= S_CHK;
        end
        S_CHK: state <= (a0 == '0) ? S_I_START : S_NORM;
        S_NORM: begin
          if (xr[31]) begin
            state <= S_SQ;
          end else begin
            xr <= {xr[30:0], 1'b0};
            sh <= sh + 5'd1;
          end
        end
        S_SQ: state <= S_SQ2;
        S_SQ2: begin
          // Squaring log2: each overflow past 2.0 yields one fraction bit.
          frac <= {frac[30:0], y2[32]};
          xr <= y2[32] ? y2[32:1] : y2[31:0];
          it <= it + 5'd1;
          state <= (it == 5'd31) ? S_LN1 : S_SQ;
        end
        S_LN1: state <= S_LN2;
        S_LN2: begin
          nlacc <= prod[63:32];
          state <= S_LN3;
        end
        S_LN3: begin
          num <= prod[NUM_W-1:0] + NUM_W'(nlacc);
          state <= S_DIVS;
        end
        S_DIVS: state <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            now_time <= t_sum[TIME_W] ? '1 : t_sum[TIME_W-1:0];
            state <= S_T1;
          end
        end
        S_T1: state <= S_T2;
        S_T2: begin
          nlacc <= prod[63:32];
          state <= S_T3;
        end
        S_T3: begin
          target <= prod[A0_W-1:0] + A0_W'(nlacc);
          k <= '0;
          cum <= '0;
          state <= S_C_RD;
        end
        S_C_RD: state <= S_C_CMP;
        S_C_CMP: begin
          cum <= cum_c;
          if (cum_c > target) begin
            kind <= K_CHARGE;
            state <= S_P_RD;
          end else if (k == SP_W'(NSPEC - 1)) begin
            k <= '0;
            state <= S_D_RD;
          end else begin
            k <= k + SP_W'(1);
            state <= S_C_RD;
          end
        end
        S_D_RD: state <= S_D_MUL;
        S_D_MUL: state <= S_D_CMP;
        S_D_CMP: begin
          cum <= cum_d;
          if (cum_d > target) begin
            kind <= K_DECAY;
            state <= S_P_RD;
          end else if (k == SP_W'(NSPEC - 1)) begin
            i_cnt <= '0;
            state <= S_W_RD;
          end else begin
            k <= k + SP_W'(1);
            state <= S_D_RD;
          end
        end
        S_P_RD: state <= S_P_WR;
        S_P_WR: begin
          species <= k;
          scount <= (kind == K_CHARGE) ? pool_inc : pool_dec;
          state <= S_I_START;
        end
        S_W_RD: state <= S_W_CMP;
        S_W_CMP: begin
          cum <= cum_w;
          if (i_cnt == nr) begin
            state <= S_NEW;
          end else if (cum_w > target) begin
            if (w_rd == W_COMP) begin
              kind <= K_COMPLETE;
              i_cnt <= '0;
              state <= S_K_RD;
            end else begin
              kind <= K_ELONGATE;
              slot <= i_cnt;
              state <= S_E_RD;
            end
          end else begin
            i_cnt <= i_nx;
            state <= S_W_RD;
          end
        end
        S_NEW: begin
          kind <= K_INITIATE;
          slot <= nr;
          newpos <= POS_W'(1);
          nr <= nr + NW'(1);
          state <= S_I_START;
        end
        S_K_RD: begin
          if (i_nx < nr) begin
            state <= S_K_WR;
          end else begin
            nr <= nr - NW'(1);
            state <= S_K_NP;
          end
        end
        S_K_WR: begin
          i_cnt <= i_nx;
          state <= S_K_RD;
        end
        S_K_NP: state <= S_K_NP2;
        S_K_NP2: begin
          newpos <= rib_rd;
          state <= S_I_START;
        end
        S_E_RD: state <= S_E_POS;
        S_E_POS: begin
          cur_pos <= rib_rd;
          state <= S_E_SP;
        end
        S_E_SP: begin
          cur_sp <= cod_rd;
          state <= S_E_WR;
        end
        S_E_WR: begin
          newpos <= cur_pos + POS_W'(1);
          if (in_gene(cur_pos) && (cur_sp < SP_W'(NSPEC))) begin
            species <= cur_sp;
            scount <= pool_dec;
          end
          state <= S_I_START;
        end
        S_I_START: begin
          i_cnt <= '0;
          c <= '0;
          acc <= '0;
          state <= S_I_RD;
        end
        S_I_RD: begin
          if (i_cnt == nr) begin
            inten[c] <= (32'(acc) > 32'hFFFFFF) ? '1 : INT_W'(acc);
            acc <= '0;
            i_cnt <= '0;
            c <= c + 2'd1;
            if (c == 2'(COLORS - 1)) state <= S_OUT;
          end else begin
            state <= S_I_POS;
          end
        end
        S_I_POS: begin
          cur_pos <= rib_rd;
          state <= S_I_ADD;
        end
        S_I_ADD: begin
          if (in_gene(cur_pos)) acc <= acc + ACC_W'(prb_rd);
          i_cnt <= i_nx;
          state <= S_I_RD;
        end
        S_OUT: begin
          if (!results.valid || results.ready) begin
            results.valid <= 1'b1;
            results.sim_time <= now_time;
            results.reaction_kind <= kind;
            results.species <= species;
            results.species_count <= scount;
            results.rib_slot <= SLOT_W'(slot);
            results.rib_position <= newpos;
            results.ribosome_count <= (32'(nr) > 32'd255) ? '1 : RCNT_W'(nr);
            results.intensity_0 <= inten[0];
            results.intensity_1 <= inten[1];
            results.intensity_2 <= inten[2];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rise_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(state) == S_OUT)
    else $error("result beat raised outside the output state");
  a_nr_bound: assert property (@(posedge clk) disable iff (rst)
    32'(nr) <= MAX_RIBOSOMES)
    else $error("ribosome count beyond capacity");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIVW)
    else $error("divider finished while not awaited");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (results.ready || !results.valid)) |=> results.valid)
    else $error("free output register not loaded");
`endif

endmodule

[verif/tb_top.sv]
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gts_pkg::*;

  localparam int NRIB        = 256;
  localparam int NPOS        = 4096;
  localparam int STALL_LIMIT = 200000;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [TIME_W-1:0] sim_time;
    kind_t             kind;
    logic [SP_W-1:0]   species;
    logic [CNT_W-1:0]  count;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  position;
    logic [RCNT_W-1:0] nrib;
    logic [INT_W-1:0]  inten0;
    logic [INT_W-1:0]  inten1;
    logic [INT_W-1:0]  inten2;
  } step_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  reg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gts_in_if items();
  gts_out_if results();

  gillespie_translation_step_top uut (
    .clk(clk),
    .rst(rst),
    .items(items),
    .results(results),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Predictor state.
  logic [31:0] bind_rate, complete_rate, elong_rate, diffuse_rate;
  logic [5:0]  fp_gap;
  logic [11:0] gene_len;
  logic        inhibit_on;
  logic [47:0] inhibit_at;
  logic [11:0] rib_pos [NRIB];
  logic [5:0]  codon_map [NPOS];
  logic [31:0] charge_rate [NSPEC];
  logic [15:0] pool [NSPEC];
  logic [15:0] probe [3][NPOS];
  logic [47:0] now_t;

  step_result_t pending_steps[$];
  int failures = 0;
  int beats_sent = 0;
  int steps_checked = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int idle_cycles = 0;

  function automatic longint unsigned neg_ln_fixed(input logic [31:0] r);
    longint unsigned x, y, frac, nl2;
    int k;
    x = (r == 0) ? 64'd1 : 64'(r);
    k = 31;
    while (!x[k]) k--;
    y = x << (31 - k);
    frac = 0;
    for (int i = 0; i < 32; i++) begin
      y = (y * y) >> 31;
      frac = frac << 1;
      if (y >= 64'h1_0000_0000) begin
        frac = frac | 64'd1;
        y = y >> 1;
      end
    end
    nl2 = (64'(32 - k) << 32) - frac;
    return (nl2 >> 32) * 64'(LN2_Q32) + (((nl2 & 64'hFFFF_FFFF) * 64'(LN2_Q32)) >> 32);
  endfunction

  function automatic longint unsigned trna_weight(input int k);
    if (k < NSPEC) return 64'(charge_rate[k]);
    return 64'(pool[k - NSPEC]) * 64'(diffuse_rate);
  endfunction

  task automatic predict_step(input logic [31:0] rt, input logic [31:0] rp);
    longint unsigned ribw [NRIB + 1];
    longint unsigned a0, w, cum, target, t, sum;
    int nr, chosen, sel;
    logic [11:0] p;
    step_result_t r;
    nr = 0;
    while (nr < NRIB && rib_pos[nr] != 0) nr++;
    a0 = 0;
    for (int k = 0; k < 2 * NSPEC; k++) a0 += trna_weight(k);
    for (int i = 0; i < nr; i++) begin
      p = rib_pos[i];
      if (i == 0 && p >= gene_len) begin
        w = 64'(complete_rate);
      end else begin
        w = 64'(elong_rate);
        if (i > 0 && (int'(rib_pos[i-1]) - int'(p)) <= int'(fp_gap)) w = 0;
        if (i > 0 && p >= gene_len) w = 0;
        if (codon_map[p] >= NSPEC) w = 0;
        else if (pool[codon_map[p]] == 0) w = 0;
      end
      ribw[i] = w;
    end
    w = 0;
    if (nr < NRIB - 1 && (nr == 0 || rib_pos[nr-1] > fp_gap) &&
        !(inhibit_on && now_t >= inhibit_at)) w = 64'(bind_rate);
    ribw[nr] = w;
    a0 += w;
    for (int i = 0; i < nr; i++) a0 += ribw[i];

    r = '0;
    r.kind = K_NONE;
    if (a0 != 0) begin
      t = 64'(now_t) + neg_ln_fixed(rt) / a0;
      now_t = (t > 64'(TIME_MAX)) ? TIME_MAX : t[47:0];
      target = 64'(rp) * (a0 >> 32) + ((64'(rp) * (a0 & 64'hFFFF_FFFF)) >> 32);
      cum = 0;
      chosen = -1;
      for (int k = 0; k < 2 * NSPEC; k++) begin
        cum += trna_weight(k);
        if (cum > target) begin
          chosen = k;
          break;
        end
      end
      if (chosen >= 0) begin
        if (chosen < NSPEC) begin
          r.kind = K_CHARGE;
          r.species = chosen[5:0];
          if (pool[chosen] < 16'hFFFF) pool[chosen]++;
        end else begin
          r.kind = K_DECAY;
          r.species = 6'(chosen - NSPEC);
          if (pool[r.species] > 0) pool[r.species]--;
        end
        r.count = pool[r.species];
      end else begin
        sel = nr;
        for (int i = 0; i <= nr; i++) begin
          cum += ribw[i];
          if (cum > target) begin
            sel = i;
            break;
          end
        end
        if (sel == nr) begin
          r.kind = K_INITIATE;
          rib_pos[nr] = 12'd1;
          r.slot = nr[7:0];
          r.position = 12'd1;
          nr++;
        end else if (sel == 0 && rib_pos[0] >= gene_len) begin
          // A finished ribosome leaves and every other one moves up a slot.
          r.kind = K_COMPLETE;
          for (int i = 0; i + 1 < nr; i++) rib_pos[i] = rib_pos[i+1];
          rib_pos[nr-1] = 12'd0;
          nr--;
          r.position = rib_pos[0];
        end else begin
          p = rib_pos[sel];
          r.kind = K_ELONGATE;
          if (codon_map[p] < NSPEC) begin
            r.species = codon_map[p];
            if (pool[r.species] > 0) pool[r.species]--;
            r.count = pool[r.species];
          end
          rib_pos[sel] = p + 12'd1;
          r.slot = sel[7:0];
          r.position = rib_pos[sel];
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      sum = 0;
      for (int i = 0; i < nr; i++) sum += 64'(probe[c][rib_pos[i]]);
      if (sum > 64'hFF_FFFF) sum = 64'hFF_FFFF;
      if (c == 0) r.inten0 = sum[23:0];
      else if (c == 1) r.inten1 = sum[23:0];
      else r.inten2 = sum[23:0];
    end
    r.sim_time = now_t;
    r.nrib = (nr > 255) ? 8'd255 : nr[7:0];
    pending_steps.push_back(r);
  endtask

  task automatic apply_beat(input func_t f, input logic [11:0] idx, input logic [1:0] col,
                            input logic [47:0] val, input logic [31:0] rt,
                            input logic [31:0] rp);
    case (f)
      FN_CODON:  codon_map[idx] = val[5:0];
      FN_CHARGE: if (idx < NSPEC) charge_rate[idx] = val[31:0];
      FN_PROBE:  if (col < 3) probe[col][idx] = val[15:0];
      FN_START:  if (idx < NRIB) rib_pos[idx] = val[11:0];
      FN_TIME:   now_t = val;
      FN_EVENT:  predict_step(rt, rp);
      default: ;
    endcase
  endtask

  task automatic send_beat(input func_t f, input logic [11:0] idx, input logic [1:0] col,
                           input logic [47:0] val, input logic [31:0] rt,
                           input logic [31:0] rp);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      items.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items.func <= f;
    items.index <= idx;
    items.color <= col;
    items.value <= val;
    items.random_time <= rt;
    items.random_pick <= rp;
    items.valid <= 1'b1;
    do @(posedge clk); while (items.ready !== 1'b1);
    apply_beat(f, idx, col, val, rt, rp);
    beats_sent++;
  endtask

  task automatic send_event(input logic [31:0] rt, input logic [31:0] rp);
    send_beat(FN_EVENT, 12'd0, 2'd0, 48'd0, rt, rp);
  endtask

  task automatic send_load(input func_t f, input logic [11:0] idx, input logic [47:0] val);
    send_beat(f, idx, 2'd0, val, 32'd0, 32'd0);
  endtask

  // Loads give no result, so a short pause after the last result leaves the block idle.
  task automatic drain;
    items.valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [47:0] d);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (r)
      REG_RATE_BIND:     bind_rate = d[31:0];
      REG_RATE_COMPLETE: complete_rate = d[31:0];
      REG_RATE_ELONG:    elong_rate = d[31:0];
      REG_RATE_DIFFUSE:  diffuse_rate = d[31:0];
      REG_FOOTPRINT:     fp_gap = d[5:0];
      REG_GENE_LENGTH:   gene_len = d[11:0];
      REG_INHIBIT_EN:    inhibit_on = d[0];
      REG_INHIBIT_TIME:  inhibit_at = d;
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
      failures++;
    end
  endtask

  always @(posedge clk) begin : result_check
    step_result_t e;
    if (rst !== 1'b1 && results.valid === 1'b1 && results.ready === 1'b1) begin
      if (pending_steps.size() == 0) begin
        $display("%0t: result beat with nothing expected, kind %0d", $time,
                 results.reaction_kind);
        failures++;
      end else begin
        e = pending_steps.pop_front();
        check_field("sim_time", 64'(e.sim_time), 64'(results.sim_time));
        check_field("reaction_kind", 64'(e.kind), 64'(results.reaction_kind));
        check_field("species", 64'(e.species), 64'(results.species));
        check_field("species_count", 64'(e.count), 64'(results.species_count));
        check_field("rib_slot", 64'(e.slot), 64'(results.rib_slot));
        check_field("rib_position", 64'(e.position), 64'(results.rib_position));
        check_field("ribosome_count", 64'(e.nrib), 64'(results.ribosome_count));
        check_field("intensity_0", 64'(e.inten0), 64'(results.intensity_0));
        check_field("intensity_1", 64'(e.inten1), 64'(results.intensity_1));
        check_field("intensity_2", 64'(e.inten2), 64'(results.intensity_2));
        steps_checked++;
      end
    end
  end

  always @(posedge clk) begin
    results.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst === 1'b1 || (items.valid === 1'b1 && items.ready === 1'b1) ||
        (results.valid === 1'b1 && results.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [31:0] pick_rate;
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return 32'($urandom_range(32'h100, 32'h4_0000));
    endcase
  endfunction

  function automatic logic [47:0] rand48;
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Every codon and probe entry is written so that no event ever reads an unwritten one.
  task automatic load_tables;
    for (int p = 0; p < NPOS; p++) begin
      if ($urandom_range(15) == 0) send_load(FN_CODON, p[11:0], 48'($urandom_range(61, 63)));
      else send_load(FN_CODON, p[11:0], {rand48() & 48'hFFFF_FFFF_FFC0} |
                                        48'($urandom_range(0, 60)));
    end
    for (int c = 0; c < 3; c++) begin
      for (int p = 0; p < NPOS; p++) begin
        send_beat(FN_PROBE, p[11:0], c[1:0], ($urandom_range(15) == 0) ? 48'hFFFF : rand48(),
                  32'd0, 32'd0);
      end
    end
    for (int s = 0; s < NSPEC; s++) send_load(FN_CHARGE, s[11:0], 48'd0);
  endtask

  task automatic test_no_reaction;
    send_event(32'd0, 32'd0);
    send_event(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_load(3'd6, 12'hFFF, TIME_MAX);
    send_load(3'd7, 12'd0, TIME_MAX);
    send_load(FN_CHARGE, 12'd61, 48'hFFFF_FFFF);
    send_load(FN_CHARGE, 12'hFFF, 48'hFFFF_FFFF);
    send_beat(FN_PROBE, 12'd5, 2'd3, 48'hFFFF, 32'd0, 32'd0);
    send_load(FN_START, 12'd256, 48'd7);
    send_load(FN_START, 12'hFFF, 48'd7);
    send_event(32'h8000_0000, 32'h1234_5678);
  endtask

  task automatic test_directed;
    drain();
    write_reg(REG_RATE_BIND, 48'h1_0000);
    write_reg(REG_RATE_COMPLETE, 48'h3_0000);
    write_reg(REG_RATE_ELONG, 48'h2_0000);
    write_reg(REG_RATE_DIFFUSE, 48'h100);
    write_reg(REG_FOOTPRINT, 48'd2);
    write_reg(REG_GENE_LENGTH, 48'd12);
    write_reg(REG_INHIBIT_EN, 48'd0);
    write_reg(REG_INHIBIT_TIME, 48'd0);
    for (int s = 0; s < NSPEC; s++) send_load(FN_CHARGE, s[11:0], 48'(32'h8000 + s));
    send_event(32'd0, 32'd0);
    send_event(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_event($urandom, $urandom);
    // A finished ribosome in front, one blocked by the footprint behind it.
    send_load(FN_START, 12'd0, 48'd12);
    send_load(FN_START, 12'd1, 48'd11);
    send_load(FN_START, 12'd2, 48'd5);
    send_load(FN_START, 12'd3, 48'd0);
    send_event($urandom, 32'hFFFF_FFFF);
    send_event($urandom, 32'hF000_0000);
    send_load(FN_TIME, 12'd0, TIME_MAX - 48'd16);
    send_event(32'd1, $urandom);
    send_load(FN_TIME, 12'd0, 48'd0);
    drain();
    write_reg(REG_INHIBIT_EN, 48'd1);
    send_event($urandom, 32'hFFFF_FFFF);
    drain();
    write_reg(REG_INHIBIT_TIME, TIME_MAX);
    send_event($urandom, 32'hFFFF_FFFF);
  endtask

  task automatic test_crowded;
    drain();
    write_reg(REG_FOOTPRINT, 48'd0);
    write_reg(REG_GENE_LENGTH, 48'd4095);
    for (int i = 0; i < NRIB; i++) send_load(FN_START, i[11:0], 48'(1000 - 3 * i));
    send_event($urandom, $urandom);
    send_load(FN_START, 12'd255, 48'd0);
    send_event($urandom, 32'hFFFF_FFFF);
    send_load(FN_START, 12'd0, 48'd0);
  endtask

  task automatic randomize_regs;
    drain();
    write_reg(REG_RATE_BIND, 48'(pick_rate()));
    write_reg(REG_RATE_COMPLETE, 48'(pick_rate()));
    write_reg(REG_RATE_ELONG, 48'(pick_rate()));
    write_reg(REG_RATE_DIFFUSE, ($urandom_range(3) == 0) ? 48'(pick_rate()) :
                                48'($urandom_range(0, 32'h400)));
    case ($urandom_range(5))
      0: write_reg(REG_FOOTPRINT, 48'd63);
      1: write_reg(REG_FOOTPRINT, 48'd0);
      default: write_reg(REG_FOOTPRINT, 48'($urandom_range(1, 12)));
    endcase
    case ($urandom_range(7))
      0: write_reg(REG_GENE_LENGTH, 48'd4095);
      1: write_reg(REG_GENE_LENGTH, 48'd1);
      default: write_reg(REG_GENE_LENGTH, 48'($urandom_range(8, 60)));
    endcase
    write_reg(REG_INHIBIT_EN, 48'($urandom_range(1)));
    case ($urandom_range(3))
      0: write_reg(REG_INHIBIT_TIME, 48'd0);
      1: write_reg(REG_INHIBIT_TIME, TIME_MAX);
      default: write_reg(REG_INHIBIT_TIME, 48'(now_t) + 48'($urandom_range(0, 32'h10_0000)));
    endcase
  endtask

  task automatic test_random(input int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) randomize_regs();
      sel = $urandom_range(99);
      if (sel < 62) send_event($urandom, $urandom);
      else if (sel < 72) send_load(FN_START, 12'($urandom_range(0, 7)),
                                   ($urandom_range(3) == 0) ? rand48() :
                                   48'($urandom_range(1, 64)));
      else if (sel < 82) send_load(FN_CHARGE, 12'($urandom_range(0, 60)),
                                   ($urandom_range(9) == 0) ? rand48() :
                                   48'($urandom_range(0, 32'h2_0000)));
      else if (sel < 86) send_load(FN_CODON, 12'($urandom), rand48());
      else if (sel < 90) send_beat(FN_PROBE, 12'($urandom), 2'($urandom), rand48(),
                                   $urandom, $urandom);
      else if (sel < 93) send_load(FN_TIME, 12'($urandom),
                                   ($urandom_range(3) == 0) ? rand48() :
                                   48'($urandom_range(0, 32'hFFFF)));
      else if (sel < 96) send_beat(func_t'($urandom_range(6, 7)), 12'($urandom),
                                   2'($urandom), rand48(), $urandom, $urandom);
      else send_load(FN_START, 12'd0, 48'd0);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_RATE_BIND;
    cfg_data = '0;
    items.valid = 1'b0;
    items.func = FN_CODON;
    items.index = '0;
    items.color = '0;
    items.value = '0;
    items.random_time = '0;
    items.random_pick = '0;
    results.ready = 1'b0;
    bind_rate = 0;
    complete_rate = 0;
    elong_rate = 0;
    diffuse_rate = 0;
    fp_gap = 6'd9;
    gene_len = 12'd1;
    inhibit_on = 1'b0;
    inhibit_at = '0;
    now_t = '0;
    for (int i = 0; i < NRIB; i++) rib_pos[i] = '0;
    for (int s = 0; s < NSPEC; s++) begin
      pool[s] = '0;
      charge_rate[s] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_idle = 27;
    recv_idle = 84;
    load_tables();
    test_no_reaction();
    test_directed();
    test_crowded();
    test_random(130);
    drain();
    send_idle = 84;
    recv_idle = 27;
    test_random(130);
    drain();
    send_idle = 0;
    recv_idle = 0;
    test_random(140);

    drain();
    repeat (200) @(posedge clk);
    $display("Covered %0d beats: table loads, bad loads, crowded and empty transcripts,",
             beats_sent);
    $display("inhibition, time saturation and %0d checked events under three idle mixes.",
             steps_checked);
    if (failures == 0 && pending_steps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
